>>> rtl/dcsc_pkg.sv
// Shared types and constants of the drive command speed controller.
`default_nettype none

package dcsc_pkg;

  // Item opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_PULSE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_BAD_SUM   = 3'd2;
  localparam logic [2:0] ST_BAD_START = 3'd3;
  localparam logic [2:0] ST_WDOG      = 3'd4;

  // Configuration register indexes
  localparam int unsigned     CFG_IDX_W        = 3;
  localparam int unsigned     CFG_DATA_W       = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WDOG_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OBST_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_IDLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN   = 3'd5;

  // Configuration reset values
  localparam logic [15:0] WDOG_TICKS_RST = 16'd100;
  localparam logic [15:0] MEAS_TICKS_RST = 16'd50;
  localparam logic [7:0]  SPEED_THR_RST  = 8'd155;
  localparam logic [9:0]  OBST_LIMIT_RST = 10'd20;
  localparam logic [11:0] STEER_IDLE_RST = 12'd870;
  localparam logic [7:0]  ERROR_GAIN_RST = 8'd31;

  // State reset values
  localparam logic [11:0] STEER_RST = 12'd870;
  localparam logic [11:0] MOTOR_RST = 12'd895;

  localparam int unsigned COUNTER_WIDTH_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH           = 4;

  typedef struct packed {
    logic [15:0] watchdog_ticks;
    logic [15:0] measure_ticks;
    logic [7:0]  speed_threshold;
    logic [9:0]  obstacle_limit;
    logic [11:0] steer_idle_pwm;
    logic [7:0]  error_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    K_NONE      = 3'd0,
    K_OK        = 3'd1,
    K_BAD_SUM   = 3'd2,
    K_BAD_START = 3'd3,
    K_PULSE     = 3'd4,
    K_TICK      = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] setpoint;
    logic [11:0] steer;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/drive_command_speed_controller.sv
// Top level of the drive command speed controller.
//
// Each item is a received UART byte, a wheel pulse or a 10 ms control tick, and
// every accepted item gives exactly one result carrying the motor and steering
// duty, the frame status, the speed setpoint, the measured wheel speed and the
// odometer. Four-byte frames (start 0x01, speed, steer, XOR checksum) set the
// setpoint and steering; a watchdog rearmed by valid frames idles the steering
// and clears the setpoint on expiry. A front end assembles and checks frames
// and works out setpoint and steering for a frame in the cycle that its last
// byte is accepted; a four-entry queue hands items to a back end that applies
// them, one per cycle unless stalled, in order: frame effects, pulse counting,
// measurement every measure_ticks ticks, watchdog, then proportional motor
// control. An item is accepted in any cycle in which the queue has room, so
// one item per cycle is sustained while results are taken; a result is offered
// once its item has passed the queue and the result register. Wheel speed and
// distance per measure period are kept as running quotient and remainder per
// pulse, so measurement needs no divider. Configuration writes are always
// ready and take effect at once; write only while no item is in flight.
`default_nettype none

module drive_command_speed_controller
  import dcsc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command items
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire logic [1:0]            opcode,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [9:0]            obstacle_distance,
  // result items
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output logic [11:0]                motor_duty,
  output logic [11:0]                steering_duty,
  output logic [2:0]                 frame_status,
  output logic [13:0]                target_speed,
  output logic [15:0]                wheel_speed,
  output logic [31:0]                odometer,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  entry_t front_entry;
  entry_t head_entry;
  logic   accept;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;

  // Writes never wait
  assign cfg_ready = 1'b1;

  // Hold the command channel while the queue is full
  assign cmd_stall = q_full;
  assign accept    = cmd_valid && !cmd_stall;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.watchdog_ticks  <= WDOG_TICKS_RST;
      cfg.measure_ticks   <= MEAS_TICKS_RST;
      cfg.speed_threshold <= SPEED_THR_RST;
      cfg.obstacle_limit  <= OBST_LIMIT_RST;
      cfg.steer_idle_pwm  <= STEER_IDLE_RST;
      cfg.error_gain      <= ERROR_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WDOG_TICKS: cfg.watchdog_ticks  <= cfg_data[15:0];
        REG_MEAS_TICKS: cfg.measure_ticks   <= cfg_data[15:0];
        REG_SPEED_THR:  cfg.speed_threshold <= cfg_data[7:0];
        REG_OBST_LIMIT: cfg.obstacle_limit  <= cfg_data[9:0];
        REG_STEER_IDLE: cfg.steer_idle_pwm  <= cfg_data[11:0];
        REG_ERROR_GAIN: cfg.error_gain      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  dcsc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .accept            (accept),
    .opcode            (opcode),
    .rx_byte           (rx_byte),
    .obstacle_distance (obstacle_distance),
    .entry             (front_entry)
  );

  dcsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (head_entry),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  dcsc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_not_empty),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .motor_duty    (motor_duty),
    .steering_duty (steering_duty),
    .frame_status  (frame_status),
    .target_speed  (target_speed),
    .wheel_speed   (wheel_speed),
    .odometer      (odometer)
  );

endmodule

`default_nettype wire

>>> rtl/dcsc_front.sv
// Front end: frame assembly, frame checks and item classification.
`default_nettype none

module dcsc_front
  import dcsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] rx_byte,
  input  wire logic [9:0] obstacle_distance,
  output entry_t          entry
);

  localparam logic [1:0]  FRAME_LAST  = 2'd3;
  localparam logic [7:0]  START_BYTE  = 8'h01;
  // 2768/25 folded with a 2^-25 reciprocal of 25
  localparam logic [39:0] SPD_RECIP   = 40'd3715148704;
  localparam logic [14:0] SPD_OFFSET  = 15'd15712;
  localparam logic [14:0] SPD_MAX     = 15'd16383;
  // 13/10 as 85202 / 2^16
  localparam logic [24:0] STEER_RECIP = 25'd85202;
  localparam logic [11:0] STEER_BASE  = 12'd700;

  logic [1:0] byte_position;
  logic [7:0] frame_store [3];

  function automatic logic [13:0] setpoint_of(input logic [7:0] s, input logic [7:0] thr);
    logic [39:0] prod;
    logic [14:0] q;
    logic [14:0] d;
    logic [13:0] r;
    prod = {32'd0, s} * SPD_RECIP;
    q    = prod[39:25];
    d    = q - SPD_OFFSET;
    if (s < thr || q < SPD_OFFSET) begin
      r = '0;
    end else if (d > SPD_MAX) begin
      r = SPD_MAX[13:0];
    end else begin
      r = d[13:0];
    end
    return r;
  endfunction

  function automatic logic [11:0] steer_of(input logic [7:0] a);
    logic [24:0] prod;
    prod = {17'd0, a} * STEER_RECIP;
    return STEER_BASE + {3'd0, prod[24:16]};
  endfunction

  always_comb begin
    entry.kind     = K_NONE;
    entry.setpoint = '0;
    entry.steer    = steer_of(frame_store[2]);
    if (obstacle_distance >= cfg.obstacle_limit) begin
      entry.setpoint = setpoint_of(frame_store[1], cfg.speed_threshold);
    end
    case (opcode)
      OP_BYTE: begin
        if (byte_position == FRAME_LAST) begin
          if (frame_store[0] != START_BYTE) begin
            entry.kind = K_BAD_START;
          end else if (rx_byte != (frame_store[1] ^ frame_store[2])) begin
            entry.kind = K_BAD_SUM;
          end else begin
            entry.kind = K_OK;
          end
        end
      end
      OP_PULSE: entry.kind = K_PULSE;
      OP_TICK:  entry.kind = K_TICK;
      default:  entry.kind = K_NONE;
    endcase
  end

  // Advance the byte position on every received byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept && opcode == OP_BYTE) begin
      byte_position <= (byte_position == FRAME_LAST) ? 2'd0 : byte_position + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && opcode == OP_BYTE && byte_position == 2'(i)) begin
        frame_store[i] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dcsc_queue.sv
// Short item queue between front end and back end.
`default_nettype none

module dcsc_queue
  import dcsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        not_empty,
  output logic        full
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> rtl/dcsc_back.sv
// Back end: frame effects, pulse counting, measurement, watchdog and P control.
`default_nettype none

module dcsc_back
  import dcsc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  input  wire entry_t q_entry,
  output logic        q_pop,
  output logic        res_valid,
  input  wire logic   res_stall,
  output logic [11:0] motor_duty,
  output logic [11:0] steering_duty,
  output logic [2:0]  frame_status,
  output logic [13:0] target_speed,
  output logic [15:0] wheel_speed,
  output logic [31:0] odometer
);

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned SQ_W  = CW + 4;
  localparam int unsigned DQ_W  = CW + 3;
  localparam int unsigned SX_W  = (SQ_W > 16) ? SQ_W : 17;
  localparam int unsigned DX_W  = (DQ_W > 32) ? DQ_W : 32;
  localparam int unsigned CMP_W = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] CNT_MASK = {CW{1'b1}};

  // pulses*4084/375 and pulses*2042/375 as quotient plus remainder
  localparam logic [9:0] DIVISOR  = 10'd375;
  localparam logic [9:0] SPD_FRAC = 10'd334;
  localparam logic [9:0] DST_FRAC = 10'd167;
  localparam logic [3:0] SPD_STEP = 4'd10;
  localparam logic [3:0] DST_STEP = 4'd5;
  localparam logic signed [26:0] MOTOR_BIAS = 27'sd3667558;
  localparam logic [11:0] MOTOR_MAX = 12'd4095;

  logic [13:0]     setpoint_reg;
  logic [15:0]     speed_reg;
  logic [CW-1:0]   pulse_counter;
  logic [SQ_W-1:0] spd_q;
  logic [8:0]      spd_rem;
  logic [DQ_W-1:0] dst_q;
  logic [8:0]      dst_rem;
  logic [CW-1:0]   measure_counter;
  logic [CW-1:0]   watchdog_counter;
  logic            armed;
  logic [11:0]     steer_reg;
  logic [11:0]     motor_reg;
  logic [31:0]     distance_reg;
  logic [2:0]      status;

  logic [13:0]     setpoint_next;
  logic [15:0]     speed_next;
  logic [CW-1:0]   pulse_counter_next;
  logic [SQ_W-1:0] spd_q_next;
  logic [8:0]      spd_rem_next;
  logic [DQ_W-1:0] dst_q_next;
  logic [8:0]      dst_rem_next;
  logic [CW-1:0]   measure_counter_next;
  logic [CW-1:0]   watchdog_counter_next;
  logic            armed_next;
  logic [11:0]     steer_next;
  logic [11:0]     motor_next;
  logic [31:0]     distance_next;
  logic [2:0]      status_next;

  assign q_pop = q_valid && (!res_valid || !res_stall);

  assign motor_duty    = motor_reg;
  assign steering_duty = steer_reg;
  assign frame_status  = status;
  assign target_speed  = setpoint_reg;
  assign wheel_speed   = speed_reg;
  assign odometer      = distance_reg;

  always_comb begin
    logic [9:0]         srem_add;
    logic [9:0]         drem_add;
    logic [CW-1:0]      mc_inc;
    logic [CMP_W-1:0]   lim;
    logic [CW-1:0]      wd_inc;
    logic [SX_W-1:0]    sx;
    logic [DX_W-1:0]    dx;
    logic signed [17:0] err;
    logic signed [26:0] prod;
    logic signed [26:0] v;

    setpoint_next         = setpoint_reg;
    speed_next            = speed_reg;
    pulse_counter_next    = pulse_counter;
    spd_q_next            = spd_q;
    spd_rem_next          = spd_rem;
    dst_q_next            = dst_q;
    dst_rem_next          = dst_rem;
    measure_counter_next  = measure_counter;
    watchdog_counter_next = watchdog_counter;
    armed_next            = armed;
    steer_next            = steer_reg;
    motor_next            = motor_reg;
    distance_next         = distance_reg;
    status_next           = ST_NONE;

    srem_add = {1'b0, spd_rem} + SPD_FRAC;
    drem_add = {1'b0, dst_rem} + DST_FRAC;
    mc_inc   = measure_counter + 1'b1;
    lim      = (cfg.measure_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.measure_ticks);
    wd_inc   = (watchdog_counter < CNT_MASK) ? watchdog_counter + 1'b1 : watchdog_counter;
    sx       = SX_W'(spd_q);
    dx       = DX_W'(dst_q);

    case (q_entry.kind)
      K_OK: begin
        setpoint_next         = q_entry.setpoint;
        steer_next            = q_entry.steer;
        watchdog_counter_next = '0;
        armed_next            = 1'b1;
        status_next           = ST_OK;
      end
      K_BAD_SUM:   status_next = ST_BAD_SUM;
      K_BAD_START: status_next = ST_BAD_START;
      K_PULSE: begin
        if (pulse_counter < CNT_MASK) begin
          pulse_counter_next = pulse_counter + 1'b1;
          if (srem_add >= DIVISOR) begin
            spd_rem_next = 9'(srem_add - DIVISOR);
            spd_q_next   = spd_q + SQ_W'(SPD_STEP + 4'd1);
          end else begin
            spd_rem_next = srem_add[8:0];
            spd_q_next   = spd_q + SQ_W'(SPD_STEP);
          end
          if (drem_add >= DIVISOR) begin
            dst_rem_next = 9'(drem_add - DIVISOR);
            dst_q_next   = dst_q + DQ_W'(DST_STEP + 4'd1);
          end else begin
            dst_rem_next = drem_add[8:0];
            dst_q_next   = dst_q + DQ_W'(DST_STEP);
          end
        end
      end
      K_TICK: begin
        // measurement first
        if (mc_inc == '0 || CMP_W'(mc_inc) >= lim) begin
          speed_next           = (sx > SX_W'(16'hFFFF)) ? 16'hFFFF : sx[15:0];
          distance_next        = distance_reg + dx[31:0];
          pulse_counter_next   = '0;
          spd_q_next           = '0;
          spd_rem_next         = '0;
          dst_q_next           = '0;
          dst_rem_next         = '0;
          measure_counter_next = '0;
        end else begin
          measure_counter_next = mc_inc;
        end
        // then watchdog
        if (armed) begin
          if (CMP_W'(wd_inc) >= CMP_W'(cfg.watchdog_ticks)) begin
            steer_next            = cfg.steer_idle_pwm;
            setpoint_next         = '0;
            armed_next            = 1'b0;
            watchdog_counter_next = '0;
            status_next           = ST_WDOG;
          end else begin
            watchdog_counter_next = wd_inc;
          end
        end
      end
      default: status_next = ST_NONE;
    endcase

    // then control, on the updated setpoint and speed
    err  = $signed({4'd0, setpoint_next}) - $signed({2'd0, speed_next});
    prod = $signed({1'b0, cfg.error_gain}) * err;
    v    = MOTOR_BIAS + prod;
    if (q_entry.kind == K_TICK) begin
      if (v < 0) begin
        motor_next = '0;
      end else if (v[26:12] > 15'(MOTOR_MAX)) begin
        motor_next = MOTOR_MAX;
      end else begin
        motor_next = v[23:12];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_reg     <= '0;
      speed_reg        <= '0;
      pulse_counter    <= '0;
      spd_q            <= '0;
      spd_rem          <= '0;
      dst_q            <= '0;
      dst_rem          <= '0;
      measure_counter  <= '0;
      watchdog_counter <= '0;
      armed            <= 1'b0;
      steer_reg        <= STEER_RST;
      motor_reg        <= MOTOR_RST;
      distance_reg     <= '0;
      status           <= ST_NONE;
      res_valid        <= 1'b0;
    end else begin
      if (q_pop) begin
        setpoint_reg     <= setpoint_next;
        speed_reg        <= speed_next;
        pulse_counter    <= pulse_counter_next;
        spd_q            <= spd_q_next;
        spd_rem          <= spd_rem_next;
        dst_q            <= dst_q_next;
        dst_rem          <= dst_rem_next;
        measure_counter  <= measure_counter_next;
        watchdog_counter <= watchdog_counter_next;
        armed            <= armed_next;
        steer_reg        <= steer_next;
        motor_reg        <= motor_next;
        distance_reg     <= distance_next;
        status           <= status_next;
        res_valid        <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_expiry_disarms: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_WDOG |-> !armed && setpoint_reg == '0)
    else $error("watchdog expiry left the watchdog armed or setpoint set");
  a_frame_arms: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_OK |-> armed)
    else $error("valid frame did not arm the watchdog");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, spd_rem} < DIVISOR && {1'b0, dst_rem} < DIVISOR)
    else $error("pulse remainder out of range");
`endif

endmodule

`default_nettype wire

>>> verif/drive_command_speed_checker.sv
// Checker: predicts every result of the drive command speed controller and compares it.
`default_nettype none

module drive_command_speed_checker
  import dcsc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  logic [1:0]            opcode,
  input  logic [7:0]            rx_byte,
  input  logic [9:0]            obstacle_distance,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  logic [11:0]           motor_duty,
  input  logic [11:0]           steering_duty,
  input  logic [2:0]            frame_status,
  input  logic [13:0]           target_speed,
  input  logic [15:0]           wheel_speed,
  input  logic [31:0]           odometer,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CNT_MAX = (64'd1 << COUNTER_WIDTH) - 64'd1;

  typedef struct packed {
    logic [11:0] motor;
    logic [11:0] steer;
    logic [2:0]  status;
    logic [13:0] setpoint;
    logic [15:0] speed;
    logic [31:0] odometer;
  } drive_result_t;

  cfg_t            settings;
  logic [1:0]      frame_pos;
  logic [7:0]      frame_bytes [3];
  logic [13:0]     setpoint;
  logic [15:0]     wheel_rate;
  longint unsigned pulse_count;
  longint unsigned tick_count;
  longint unsigned wdog_count;
  logic            wdog_armed;
  logic [11:0]     steer_pwm;
  logic [11:0]     motor_pwm;
  logic [31:0]     distance;

  drive_result_t expected_results [$];

  // Advance the controller by one item and return the result it gives.
  function automatic drive_result_t apply_item(input logic [1:0] op, input logic [7:0] rx,
                                               input logic [9:0] obst_dist);
    logic [2:0]      status;
    int              speed_cmd;
    longint unsigned period;
    longint unsigned rate;
    longint          drive;
    drive_result_t   res;
    status = ST_NONE;
    case (op)
      OP_BYTE: begin
        if (frame_pos != 2'd3) begin
          frame_bytes[frame_pos] = rx;
          frame_pos = frame_pos + 2'd1;
        end else begin
          frame_pos = 2'd0;
          if (frame_bytes[0] != 8'h01) begin
            status = ST_BAD_START;
          end else if (rx != (frame_bytes[1] ^ frame_bytes[2])) begin
            status = ST_BAD_SUM;
          end else begin
            status = ST_OK;
            // 16 * (6.92 * s - 982), floored
            speed_cmd = 2768 * int'(frame_bytes[1]) / 25 - 15712;
            if (obst_dist < settings.obstacle_limit ||
                frame_bytes[1] < settings.speed_threshold || speed_cmd < 0) begin
              setpoint = '0;
            end else if (speed_cmd > 16383) begin
              setpoint = 14'h3FFF;
            end else begin
              setpoint = 14'(speed_cmd);
            end
            steer_pwm = 12'(700 + 13 * int'(frame_bytes[2]) / 10);
            wdog_count = 0;
            wdog_armed = 1'b1;
          end
        end
      end
      OP_PULSE: begin
        if (pulse_count < CNT_MAX) pulse_count++;
      end
      OP_TICK: begin
        // measurement, then watchdog, then control
        period = (settings.measure_ticks == 0) ? 1 : settings.measure_ticks;
        tick_count = (tick_count + 1) & CNT_MAX;
        if (tick_count >= period || tick_count == 0) begin
          rate = pulse_count * 4084 / 375;
          wheel_rate = (rate > 65535) ? 16'hFFFF : 16'(rate);
          distance = distance + 32'(pulse_count * 2042 / 375);
          pulse_count = 0;
          tick_count = 0;
        end
        if (wdog_armed) begin
          if (wdog_count < CNT_MAX) wdog_count++;
          if (wdog_count >= settings.watchdog_ticks) begin
            steer_pwm = settings.steer_idle_pwm;
            setpoint = '0;
            wdog_armed = 1'b0;
            wdog_count = 0;
            status = ST_WDOG;
          end
        end
        // 895.4 in Q12 plus gain times speed error
        drive = 64'sd3667558 +
                longint'(settings.error_gain) * (longint'(setpoint) - longint'(wheel_rate));
        if (drive < 0) begin
          motor_pwm = '0;
        end else if ((drive >>> 12) > 4095) begin
          motor_pwm = 12'hFFF;
        end else begin
          motor_pwm = 12'(drive >>> 12);
        end
      end
      default: ;
    endcase
    res.motor    = motor_pwm;
    res.steer    = steer_pwm;
    res.status   = status;
    res.setpoint = setpoint;
    res.speed    = wheel_rate;
    res.odometer = distance;
    return res;
  endfunction

  function automatic bit field_matches(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    logic          fields_ok;
    if (rst) begin
      settings.watchdog_ticks  = WDOG_TICKS_RST;
      settings.measure_ticks   = MEAS_TICKS_RST;
      settings.speed_threshold = SPEED_THR_RST;
      settings.obstacle_limit  = OBST_LIMIT_RST;
      settings.steer_idle_pwm  = STEER_IDLE_RST;
      settings.error_gain      = ERROR_GAIN_RST;
      frame_pos   = 2'd0;
      frame_bytes = '{default: 8'h00};
      setpoint    = '0;
      wheel_rate  = '0;
      pulse_count = 0;
      tick_count  = 0;
      wdog_count  = 0;
      wdog_armed  = 1'b0;
      steer_pwm   = STEER_RST;
      motor_pwm   = MOTOR_RST;
      distance    = '0;
      expected_results.delete();
      pending  <= 0;
      failures <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WDOG_TICKS: settings.watchdog_ticks  = cfg_data;
          REG_MEAS_TICKS: settings.measure_ticks   = cfg_data;
          REG_SPEED_THR:  settings.speed_threshold = cfg_data[7:0];
          REG_OBST_LIMIT: settings.obstacle_limit  = cfg_data[9:0];
          REG_STEER_IDLE: settings.steer_idle_pwm  = cfg_data[11:0];
          REG_ERROR_GAIN: settings.error_gain      = cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) begin
        expected_results.push_back(apply_item(opcode, rx_byte, obstacle_distance));
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no item outstanding");
          failures <= failures + 1;
        end else begin
          want = expected_results.pop_front();
          fields_ok = field_matches("motor_duty", want.motor, motor_duty) &
                      field_matches("steering_duty", want.steer, steering_duty) &
                      field_matches("frame_status", want.status, frame_status) &
                      field_matches("target_speed", want.setpoint, target_speed) &
                      field_matches("wheel_speed", want.speed, wheel_speed) &
                      field_matches("odometer", want.odometer, odometer);
          if (!fields_ok) failures <= failures + 1;
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

>>> verif/drive_command_speed_controller_test.sv
// Top of the testbench: stimulus, flow control and verdict for the speed controller.
`default_nettype none

module drive_command_speed_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcsc_pkg::*;

  // The fourth opcode value has no meaning; the block gives a result with no status for it.
  localparam logic [1:0]  OP_UNUSED       = 2'd3;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 185;
  localparam int unsigned NUM_PHASES      = 6;
  // Pulses sent in one burst before a measurement.
  localparam int unsigned BURST_PULSES    = 200;

  logic                  clk               = 1'b0;
  logic                  rst               = 1'b1;
  logic                  cmd_valid         = 1'b0;
  logic [1:0]            opcode            = OP_BYTE;
  logic [7:0]            rx_byte           = 8'h00;
  logic [9:0]            obstacle_distance = 10'd0;
  logic                  res_stall         = 1'b0;
  logic                  cfg_valid         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = REG_WDOG_TICKS;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;

  logic                  cmd_stall;
  logic                  res_valid;
  logic                  cfg_ready;
  logic [11:0]           motor_duty;
  logic [11:0]           steering_duty;
  logic [2:0]            frame_status;
  logic [13:0]           target_speed;
  logic [15:0]           wheel_speed;
  logic [31:0]           odometer;

  int                    pending;
  int                    failures;

  int                    sender_idle_pct = 0;
  int                    stall_pct       = 0;
  int unsigned           items_sent      = 0;
  int unsigned           quiet_cycles    = 0;
  // Byte position of the block's frame assembler, tracked so frames can be realigned.
  logic [1:0]            frame_pos       = 2'd0;
  logic [9:0]            obst_limit_now  = OBST_LIMIT_RST;

  drive_command_speed_controller u_dut (.*);

  drive_command_speed_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver side: stall at the rate of the current phase.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("drive_command_speed_controller_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, idling first at the phase's rate, and hold it until accepted.
  task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                           input logic [9:0] obst_dist);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid         <= 1'b1;
    opcode            <= op;
    rx_byte           <= rx;
    obstacle_distance <= obst_dist;
    do @(posedge clk); while (cmd_stall);
    if (op == OP_BYTE) frame_pos = frame_pos + 2'd1;
    items_sent++;
  endtask

  // Send a four-byte frame; pulses and ticks may fall between its bytes.
  task automatic send_frame(input logic [7:0] start_byte, input logic [7:0] speed_byte,
                            input logic [7:0] steer_byte, input logic [7:0] check_byte,
                            input logic [9:0] obst_dist);
    logic [7:0] frame_bytes [4];
    frame_bytes = '{start_byte, speed_byte, steer_byte, check_byte};
    // pad with stray bytes until the assembler is back at the start of a frame
    while (frame_pos != 2'd0) begin
      send_item(OP_BYTE, 8'($urandom_range(255)), 10'($urandom_range(1023)));
    end
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(9) < 2) begin
        send_item($urandom_range(1) ? OP_PULSE : OP_TICK, 8'($urandom_range(255)),
                  10'($urandom_range(1023)));
      end
      send_item(OP_BYTE, frame_bytes[i], (i == 3) ? obst_dist : 10'($urandom_range(1023)));
    end
  endtask

  // Distance for the closing byte: now and then inside the obstacle limit.
  function automatic logic [9:0] pick_distance();
    if (obst_limit_now != 0 && $urandom_range(3) == 0) begin
      return 10'($urandom_range(obst_limit_now - 1));
    end
    return 10'($urandom_range(1023, obst_limit_now));
  endfunction

  // Mostly well-formed frames; some with a broken checksum or start byte.
  task automatic random_frame();
    logic [7:0] start_byte;
    logic [7:0] speed_byte;
    logic [7:0] steer_byte;
    logic [7:0] check_byte;
    int         pick;
    start_byte = 8'h01;
    speed_byte = 8'($urandom_range(255));
    steer_byte = 8'($urandom_range(255));
    check_byte = speed_byte ^ steer_byte;
    pick = $urandom_range(99);
    if (pick < 8) begin
      check_byte = check_byte ^ 8'($urandom_range(255, 1));
    end else if (pick < 14) begin
      start_byte = 8'h01 ^ 8'($urandom_range(255, 1));
    end
    send_frame(start_byte, speed_byte, steer_byte, check_byte, pick_distance());
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at;
    int          pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        random_frame();
      end else if (pick < 70) begin
        send_item(OP_PULSE, 8'($urandom_range(255)), 10'($urandom_range(1023)));
      end else if (pick < 92) begin
        send_item(OP_TICK, 8'($urandom_range(255)), 10'($urandom_range(1023)));
      end else if (pick < 97) begin
        // stray byte: knocks the assembler out of step with the next frame
        send_item(OP_BYTE, 8'($urandom_range(255)), 10'($urandom_range(1023)));
      end else begin
        send_item(OP_UNUSED, 8'($urandom_range(255)), 10'($urandom_range(1023)));
      end
    end
  endtask

  // Drain every outstanding result, then write all six registers.
  task automatic apply_settings(input logic [15:0] wdog_ticks, input logic [15:0] meas_ticks,
                                input logic [7:0] speed_thr, input logic [9:0] obst_limit,
                                input logic [11:0] steer_idle, input logic [7:0] gain);
    logic [CFG_IDX_W-1:0]  reg_index [6];
    logic [CFG_DATA_W-1:0] reg_value [6];
    reg_index = '{REG_WDOG_TICKS, REG_MEAS_TICKS, REG_SPEED_THR,
                  REG_OBST_LIMIT, REG_STEER_IDLE, REG_ERROR_GAIN};
    reg_value = '{wdog_ticks, meas_ticks, 16'(speed_thr), 16'(obst_limit),
                  16'(steer_idle), 16'(gain)};
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data  <= reg_value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    obst_limit_now = obst_limit;
  endtask

  initial begin
    // hold reset, then release
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under reset settings.
    send_item(OP_TICK, 8'h00, 10'd0);
    // full speed and full steering, far from any obstacle
    send_frame(8'h01, 8'hFF, 8'hFF, 8'h00, 10'h3FF);
    // speed exactly at the threshold, distance exactly at the obstacle limit
    send_frame(8'h01, 8'd155, 8'd0, 8'd155, 10'd20);
    // speed just below the threshold
    send_frame(8'h01, 8'd154, 8'd100, 8'd154 ^ 8'd100, 10'd500);
    // obstacle just inside the limit: setpoint drops, steering still follows the frame
    send_frame(8'h01, 8'd200, 8'd37, 8'd200 ^ 8'd37, 10'd19);
    // wrong start byte, then wrong checksum
    send_frame(8'h00, 8'd200, 8'd50, 8'd200 ^ 8'd50, 10'd600);
    send_frame(8'h01, 8'd220, 8'd90, 8'h00, 10'd600);
    // unused opcode
    send_item(OP_UNUSED, 8'hFF, 10'h3FF);

    // Pulse burst, then measure with one-tick periods and full gain.
    apply_settings(16'd1, 16'd1, 8'd0, 10'd0, 12'd0, 8'd255);
    repeat (BURST_PULSES) send_item(OP_PULSE, 8'($urandom_range(255)), 10'($urandom_range(1023)));
    send_item(OP_TICK, 8'h00, 10'd0);
    send_item(OP_TICK, 8'hFF, 10'h3FF);

    // Random phases, each with its own settings and flow-control pattern.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(WDOG_TICKS_RST, MEAS_TICKS_RST, SPEED_THR_RST, OBST_LIMIT_RST,
                          STEER_IDLE_RST, ERROR_GAIN_RST);
        1: apply_settings(16'd1, 16'd1, 8'd0, 10'd0, 12'd0, 8'd255);
        2: apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF, 12'hFFF, 8'd0);
        3: apply_settings(16'd7, 16'd3, 8'd142, 10'd512, 12'd2048, 8'd128);
        default: apply_settings(16'($urandom_range(30, 1)), 16'($urandom_range(12, 1)),
                                8'($urandom_range(255)), 10'($urandom_range(1023)),
                                12'($urandom_range(4095)), 8'($urandom_range(255)));
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 77;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 77;
        end
        default: begin
          sender_idle_pct = 7;
          stall_pct       = 7;
        end
      endcase
      random_traffic(ITEMS_PER_PHASE);
    end

    // drop valid, drain what is left, allow for the pipeline, then decide
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("drive_command_speed_controller_test: PASS");
    end else begin
      $display("drive_command_speed_controller_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
